// File: rtl/core/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

    typedef enum logic [3:0] {
        EV_TEXT_BYTE    = 4'd0,
        EV_TEXT_END     = 4'd1,
        EV_CLOSE_BYTE   = 4'd2,
        EV_CLOSE        = 4'd3,
        EV_PONG_TX      = 4'd4,
        EV_BINARY_ERR   = 4'd5,
        EV_MASK_ERR     = 4'd6,
        EV_BAD_CONT     = 4'd7,
        EV_PONG_SEEN    = 4'd8
    } ev_code_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16      = 7'd126;
    localparam logic [6:0] LEN_EXT64      = 7'd127;
    localparam logic [3:0] LEN16_BYTES    = 4'd2;
    localparam logic [3:0] LEN64_BYTES    = 4'd8;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;
    localparam logic [7:0] PONG_BYTE0     = 8'h8A;
    localparam logic [7:0] PONG_BYTE1     = 8'h00;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  data;
        ev_code_t    ev;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r1;
        result_t r0;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/wsfr_front.sv
// Frame parser: takes one received byte per word and builds the results it causes.
`default_nettype none

module wsfr_front
    import wsfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] in_byte,
    output logic            push,
    output entry_t          push_entry
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_LEN  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [2:0]  mask_left_reg, mask_left_next;
    logic [63:0] pay_left_reg, pay_left_next;
    logic        frag_active_reg, frag_active_next;
    logic [3:0]  frag_op_reg, frag_op_next;
    logic [15:0] cc_reg, cc_next;
    logic [1:0]  seen_reg, seen_next;

    logic        accept;
    logic [3:0]  eff_op;
    logic        ld_now, ld_masked, ld_zero;
    logic        do_end, end_masked;
    logic        byte_valid;
    result_t     byte_res;
    logic        end_valid, end_pong;
    result_t     end_res;
    logic [63:0] pay_dec;
    logic [63:0] pay_shift;
    logic [3:0]  len_dec;
    logic [2:0]  mask_dec;

    assign accept    = in_valid && in_ready;
    assign eff_op    = (opcode_reg == OP_CONT && frag_active_reg) ? frag_op_reg : opcode_reg;
    assign pay_dec   = pay_left_reg - 64'd1;
    assign pay_shift = {pay_left_reg[55:0], in_byte};
    assign len_dec   = len_left_reg - 4'd1;
    assign mask_dec  = mask_left_reg - 3'd1;

    always_comb begin
        phase_next       = phase_reg;
        final_next       = final_reg;
        opcode_next      = opcode_reg;
        masked_next      = masked_reg;
        len_left_next    = len_left_reg;
        mask_left_next   = mask_left_reg;
        pay_left_next    = pay_left_reg;
        frag_active_next = frag_active_reg;
        frag_op_next     = frag_op_reg;
        cc_next          = cc_reg;
        seen_next        = seen_reg;
        ld_now           = 1'b0;
        ld_masked        = 1'b0;
        ld_zero          = 1'b0;
        do_end           = 1'b0;
        end_masked       = 1'b0;
        byte_valid       = 1'b0;
        byte_res         = '{code: 16'd0, data: 8'd0, ev: EV_TEXT_BYTE};
        end_valid        = 1'b0;
        end_pong         = 1'b0;
        end_res          = '{code: 16'd0, data: 8'd0, ev: EV_TEXT_END};

        if (accept) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    masked_next = in_byte[7];
                    if (in_byte[6:0] == LEN_EXT16) begin
                        pay_left_next = 64'd0;
                        len_left_next = LEN16_BYTES;
                        phase_next    = PH_LEN;
                    end else if (in_byte[6:0] == LEN_EXT64) begin
                        pay_left_next = 64'd0;
                        len_left_next = LEN64_BYTES;
                        phase_next    = PH_LEN;
                    end else begin
                        pay_left_next = {57'd0, in_byte[6:0]};
                        ld_now        = 1'b1;
                        ld_masked     = in_byte[7];
                        ld_zero       = (in_byte[6:0] == 7'd0);
                    end
                end
                PH_LEN: begin
                    pay_left_next = pay_shift;
                    len_left_next = len_dec;
                    if (len_dec == 4'd0) begin
                        ld_now    = 1'b1;
                        ld_masked = masked_reg;
                        ld_zero   = (pay_shift == 64'd0);
                    end
                end
                PH_MASK: begin
                    mask_left_next = mask_dec;
                    if (mask_dec == 3'd0) begin
                        byte_valid  = 1'b1;
                        byte_res.ev = EV_MASK_ERR;
                        if (pay_left_reg == 64'd0) begin
                            phase_next = PH_HDR0;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    if (!masked_reg) begin
                        if (eff_op == OP_TEXT) begin
                            byte_valid    = 1'b1;
                            byte_res.ev   = EV_TEXT_BYTE;
                            byte_res.data = in_byte;
                        end else if (eff_op == OP_CLOSE) begin
                            if (seen_reg < 2'd2) begin
                                cc_next   = {cc_reg[7:0], in_byte};
                                seen_next = seen_reg + 2'd1;
                            end else begin
                                byte_valid    = 1'b1;
                                byte_res.ev   = EV_CLOSE_BYTE;
                                byte_res.data = in_byte;
                            end
                        end
                    end
                    pay_left_next = pay_dec;
                    if (pay_dec == 64'd0) begin
                        do_end     = 1'b1;
                        end_masked = masked_reg;
                    end
                end
                default: begin
                    final_next    = in_byte[7];
                    opcode_next   = in_byte[3:0];
                    masked_next   = 1'b0;
                    cc_next       = 16'd0;
                    seen_next     = 2'd0;
                    pay_left_next = 64'd0;
                    phase_next    = PH_HDR1;
                end
            endcase

            if (ld_now) begin
                if (ld_masked) begin
                    mask_left_next = MASK_KEY_BYTES;
                    phase_next     = PH_MASK;
                end else if (ld_zero) begin
                    do_end = 1'b1;
                end else begin
                    phase_next = PH_PAY;
                end
            end

            if (do_end) begin
                phase_next = PH_HDR0;
                if (!end_masked) begin
                    if (!final_reg) begin
                        if (!frag_active_reg) begin
                            frag_active_next = 1'b1;
                            frag_op_next     = opcode_reg;
                        end
                    end else begin
                        frag_active_next = 1'b0;
                        frag_op_next     = 4'd0;
                        unique case (eff_op)
                            OP_CONT: begin
                                end_valid  = 1'b1;
                                end_res.ev = EV_BAD_CONT;
                            end
                            OP_TEXT: begin
                                end_valid  = 1'b1;
                                end_res.ev = EV_TEXT_END;
                            end
                            OP_BIN: begin
                                end_valid  = 1'b1;
                                end_res.ev = EV_BINARY_ERR;
                            end
                            OP_CLOSE: begin
                                end_valid    = 1'b1;
                                end_res.ev   = EV_CLOSE;
                                end_res.code = (seen_next == 2'd1) ? {cc_next[7:0], 8'd0}
                                                                   : cc_next;
                            end
                            OP_PING: begin
                                end_valid = 1'b1;
                                end_pong  = 1'b1;
                            end
                            OP_PONG: begin
                                end_valid  = 1'b1;
                                end_res.ev = EV_PONG_SEEN;
                            end
                            default: begin
                                end_valid = 1'b0;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_comb begin
        push_entry = '{two: 1'b0, r1: end_res, r0: byte_res};
        if (end_pong) begin
            push_entry.two = 1'b1;
            push_entry.r0  = '{code: 16'd0, data: PONG_BYTE0, ev: EV_PONG_TX};
            push_entry.r1  = '{code: 16'd0, data: PONG_BYTE1, ev: EV_PONG_TX};
        end else if (byte_valid) begin
            push_entry.two = end_valid;
        end else begin
            push_entry.r0 = end_res;
        end
    end

    assign push = byte_valid || end_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR0;
            final_reg       <= 1'b0;
            opcode_reg      <= 4'd0;
            masked_reg      <= 1'b0;
            len_left_reg    <= 4'd0;
            mask_left_reg   <= 3'd0;
            pay_left_reg    <= 64'd0;
            frag_active_reg <= 1'b0;
            frag_op_reg     <= 4'd0;
            cc_reg          <= 16'd0;
            seen_reg        <= 2'd0;
        end else begin
            phase_reg       <= phase_next;
            final_reg       <= final_next;
            opcode_reg      <= opcode_next;
            masked_reg      <= masked_next;
            len_left_reg    <= len_left_next;
            mask_left_reg   <= mask_left_next;
            pay_left_reg    <= pay_left_next;
            frag_active_reg <= frag_active_next;
            frag_op_reg     <= frag_op_next;
            cc_reg          <= cc_next;
            seen_reg        <= seen_next;
        end
    end

`ifndef SYNTH
    a_pay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |-> (pay_left_reg != 64'd0))
        else $error("payload phase entered with nothing left to count");

    a_hdr_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_HDR0) |=> (phase_reg == PH_HDR1))
        else $error("first header byte not followed by length byte phase");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wsfr_queue.sv
// Short queue of parsed result entries between the parser and the output stage.
`default_nettype none

module wsfr_queue
    import wsfr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire entry_t  push_entry,
    output logic         not_full,
    output logic         not_empty,
    input  wire logic    pop,
    output entry_t       head
);

    entry_t           mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign not_full  = (cnt_reg != QCW'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QAW'(do_push);
        rd_ptr_next = rd_ptr_reg + QAW'(do_pop);
        cnt_next    = cnt_reg + QCW'(do_push) - QCW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("entry pushed into a full queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wsfr_back.sv
// Output stage: expands queued entries into result words on a registered stream.
`default_nettype none

module wsfr_back
    import wsfr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_not_empty,
    input  wire entry_t  q_head,
    output logic         q_pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res,
    output logic         out_last
);

    logic    valid_reg, valid_next;
    logic    sel_reg, sel_next;
    result_t res_reg, res_next;
    logic    last_reg, last_next;
    logic    load;

    assign load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = q_not_empty;
            if (q_not_empty) begin
                res_next  = sel_reg ? q_head.r1 : q_head.r0;
                last_next = !q_head.two || sel_reg;
                if (q_head.two && !sel_reg) begin
                    sel_next = 1'b1;
                end else begin
                    sel_next = 1'b0;
                    q_pop    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

`ifndef SYNTH
    a_second_half: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (q_not_empty && q_head.two))
        else $error("second result pending without a two-result entry");
`endif

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_receiver.sv
// WebSocket frame receiver top level: parser, result queue and output stage.
// Accepts one byte per cycle while the queue has room; each result is queued, then registered.
// The output stage sends one word per cycle unless stalled; a two-result byte gives two words.
// A four-entry queue between parser and output stage absorbs these bursts and output stalls.
// Reset (aresetn low, synchronous) returns the parser to the first header byte
// and empties the queue and the output register.
`default_nettype none

module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // event_res[3:0], data[11:4], close_code[27:12]
    output logic             m_axis_tlast
);

    logic    push;
    entry_t  push_entry;
    logic    q_not_full;
    logic    q_not_empty;
    logic    q_pop;
    entry_t  q_head;
    result_t out_res;

    assign s_axis_tready = q_not_full;

    wsfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (q_not_full),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    wsfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    wsfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (out_res),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_res};

endmodule

`default_nettype wire
